[sv/nlr_pkg.sv]
package nlr_pkg;

    // Default saturation limit for the token length.
    localparam int LEN_LIMIT_DEF = 255;

    // Depth of the queue between the classifier and the scanner.
    localparam int Q_DEPTH = 2;

    // Character codes that the classifier looks for.
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LO    = 8'h6f;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_LJ    = 8'h6a;
    localparam logic [7:0] CH_POINT = 8'h2e;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // Token type codes.
    localparam logic [2:0] TT_BIN   = 3'd0;
    localparam logic [2:0] TT_OCT   = 3'd1;
    localparam logic [2:0] TT_HEX   = 3'd2;
    localparam logic [2:0] TT_DEC   = 3'd3;
    localparam logic [2:0] TT_FLOAT = 3'd4;
    localparam logic [2:0] TT_IMAG  = 3'd5;
    localparam logic [2:0] TT_ERR   = 3'd6;

    typedef enum logic [3:0] {
        M_IDLE,
        M_ZERO,
        M_BIN,
        M_OCT,
        M_HEX,
        M_INT,
        M_FRAC,
        M_EXPS,
        M_EXPSG,
        M_EXPD
    } t_mode;

    // Character class flags produced by the classifier.
    typedef struct packed {
        logic dec;
        logic zero;
        logic bin;
        logic oct;
        logic hex;
        logic let_b;
        logic let_o;
        logic let_x;
        logic let_e;
        logic let_j;
        logic point;
        logic sign;
    } t_cls;

endpackage

[sv/nlr_front.sv]
module nlr_front import nlr_pkg::*; (
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cls       o_cls
);

    logic [7:0] folded;

    assign o_s_axis_tready = !i_q_full;
    assign o_push          = i_s_axis_tvalid && !i_q_full;

    // Letters are compared with the case bit forced on.
    assign folded = i_s_axis_tdata | CASE_BIT;

    always_comb begin
        o_cls.dec   = (i_s_axis_tdata >= CH_0) && (i_s_axis_tdata <= CH_9);
        o_cls.zero  = (i_s_axis_tdata == CH_0);
        o_cls.bin   = (i_s_axis_tdata == CH_0) || (i_s_axis_tdata == CH_1);
        o_cls.oct   = (i_s_axis_tdata >= CH_0) && (i_s_axis_tdata <= CH_7);
        o_cls.hex   = o_cls.dec
                   || ((i_s_axis_tdata >= CH_LA) && (i_s_axis_tdata <= CH_LF))
                   || ((i_s_axis_tdata >= CH_UA) && (i_s_axis_tdata <= CH_UF));
        o_cls.let_b = (folded == CH_LB);
        o_cls.let_o = (folded == CH_LO);
        o_cls.let_x = (folded == CH_LX);
        o_cls.let_e = (folded == CH_LE);
        o_cls.let_j = (folded == CH_LJ);
        o_cls.point = (i_s_axis_tdata == CH_POINT);
        o_cls.sign  = (i_s_axis_tdata == CH_PLUS) || (i_s_axis_tdata == CH_MINUS);
    end

endmodule

[sv/nlr_queue.sv]
module nlr_queue import nlr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cls o_data
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_cls          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;

    assign o_full  = (r_count == CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[sv/nlr_back.sv]
module nlr_back import nlr_pkg::*; #(
    parameter int LEN_LIMIT = LEN_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cls        i_q_data,
    output logic        o_pop,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    localparam int         CAP   = (LEN_LIMIT < 255) ? LEN_LIMIT : 255;
    localparam logic [7:0] CAP_L = 8'(CAP);

    t_mode      r_mode;
    t_mode      n_mode;
    logic       r_saw_point;
    logic [7:0] r_count;
    logic [7:0] n_count;

    logic       take;
    logic       fin;
    logic [2:0] ttype;
    logic [2:0] base;

    logic       r_valid;
    logic       r_consumed;
    logic       r_done;
    logic [2:0] r_type;
    logic [7:0] r_len;

    t_cls c;

    assign c     = i_q_data;
    assign base  = r_saw_point ? TT_FLOAT : TT_DEC;
    assign o_pop = i_q_valid && (!r_valid || i_m_axis_tready);

    // Next scan mode.
    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            M_IDLE: begin
                if (c.dec) begin
                    n_mode = c.zero ? M_ZERO : M_INT;
                end
            end
            M_ZERO: begin
                if (c.let_b) begin
                    n_mode = M_BIN;
                end else if (c.let_o) begin
                    n_mode = M_OCT;
                end else if (c.let_x) begin
                    n_mode = M_HEX;
                end else if (c.dec) begin
                    n_mode = M_INT;
                end else if (c.point) begin
                    n_mode = M_FRAC;
                end else if (c.let_e) begin
                    n_mode = M_EXPS;
                end
            end
            M_INT: begin
                if (c.point) begin
                    n_mode = M_FRAC;
                end else if (c.let_e) begin
                    n_mode = M_EXPS;
                end
            end
            M_FRAC: begin
                if (c.let_e) begin
                    n_mode = M_EXPS;
                end
            end
            M_EXPS: begin
                if (c.sign) begin
                    n_mode = M_EXPSG;
                end else if (c.dec) begin
                    n_mode = M_EXPD;
                end
            end
            M_EXPSG, M_EXPD: begin
                if (c.dec) begin
                    n_mode = M_EXPD;
                end
            end
            M_BIN, M_OCT, M_HEX: begin
                n_mode = r_mode;
            end
            default: n_mode = M_IDLE;
        endcase
        if (fin) begin
            n_mode = M_IDLE;
        end
    end

    // Consume, end and type decisions for the current character.
    always_comb begin
        take  = 1'b0;
        fin   = 1'b0;
        ttype = TT_BIN;
        unique case (r_mode)
            M_IDLE: begin
                take = c.dec;
                if (!c.dec) begin
                    fin   = 1'b1;
                    ttype = TT_ERR;
                end
            end
            M_BIN: begin
                take = c.bin;
                if (!c.bin) begin
                    fin   = 1'b1;
                    ttype = TT_BIN;
                end
            end
            M_OCT: begin
                take = c.oct;
                if (!c.oct) begin
                    fin   = 1'b1;
                    ttype = TT_OCT;
                end
            end
            M_HEX: begin
                take = c.hex;
                if (!c.hex) begin
                    fin   = 1'b1;
                    ttype = TT_HEX;
                end
            end
            M_ZERO, M_INT: begin
                if ((r_mode == M_ZERO) && (c.let_b || c.let_o || c.let_x)) begin
                    take = 1'b1;
                end else if (c.let_j) begin
                    take  = 1'b1;
                    fin   = 1'b1;
                    ttype = TT_IMAG;
                end else if (c.dec || c.point || c.let_e) begin
                    take = 1'b1;
                end else begin
                    fin   = 1'b1;
                    ttype = TT_DEC;
                end
            end
            M_FRAC: begin
                if (c.let_j) begin
                    take  = 1'b1;
                    fin   = 1'b1;
                    ttype = TT_IMAG;
                end else if (c.dec || c.let_e) begin
                    take = 1'b1;
                end else begin
                    fin   = 1'b1;
                    ttype = TT_FLOAT;
                end
            end
            M_EXPS: begin
                if (c.let_j) begin
                    take  = 1'b1;
                    fin   = 1'b1;
                    ttype = TT_IMAG;
                end else if (c.sign || c.dec) begin
                    take = 1'b1;
                end else begin
                    fin   = 1'b1;
                    ttype = base;
                end
            end
            M_EXPSG, M_EXPD: begin
                if (c.let_j) begin
                    take  = 1'b1;
                    fin   = 1'b1;
                    ttype = TT_IMAG;
                end else if (c.dec) begin
                    take = 1'b1;
                end else begin
                    fin   = 1'b1;
                    ttype = base;
                end
            end
            default: begin
                fin   = 1'b1;
                ttype = TT_ERR;
            end
        endcase
    end

    assign n_count = (take && (r_count < CAP_L)) ? r_count + 1'b1 : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_saw_point <= 1'b0;
            r_count     <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mode <= n_mode;
                if (fin) begin
                    r_saw_point <= 1'b0;
                    r_count     <= '0;
                end else begin
                    r_count <= n_count;
                    if (((r_mode == M_ZERO) || (r_mode == M_INT)) && c.point) begin
                        r_saw_point <= 1'b1;
                    end
                end
                r_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_consumed <= take;
            r_done     <= fin;
            r_type     <= fin ? ttype : TT_BIN;
            r_len      <= n_count;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tlast  = r_done;
    assign o_m_axis_tdata  = {4'b0000, r_len, r_type, r_consumed};

endmodule

[sv/numeric_literal_recognizer_top.sv]
// Numeric literal recognizer. Text bytes enter one per beat on the slave
// stream; every byte produces exactly one result beat on the master stream,
// in order. A result says whether its byte belongs to the number (tdata bit
// 0), whether the token ended with this byte (tlast), the token type when it
// ended (0 binary, 1 octal, 2 hex, 3 decimal, 4 float, 5 imaginary, 6 error,
// and 0 while the token is still open) and the number of bytes consumed so
// far, which saturates at the smaller of LEN_LIMIT and 255. A byte that is not
// consumed ends the token and must be sent again by the host as the first
// byte of the next token; a consumed j or J ends the token as well. The block
// takes one byte per clock cycle while the result stream is not stalled: a
// classifier decodes each byte into character classes, a two-entry queue
// holds the decoded bytes, and a scanner state machine with the length
// counter updates once per byte and writes the result into an output
// register. Each side stalls independently; the per-byte state update of the
// scanner sets the throughput.
module numeric_literal_recognizer_top import nlr_pkg::*; #(
    parameter int LEN_LIMIT = LEN_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [0] consumed, [3:1] token_type,
                                          // [11:4] token_len, [15:12] zero
    output logic        o_m_axis_tlast    // done_res
);

    // Front side: classification of the incoming byte.
    logic push;
    logic q_full;
    t_cls cls_in;

    // Queue to scanner.
    logic q_valid;
    logic pop;
    t_cls cls_out;

    nlr_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_cls           (cls_in)
    );

    // The queue decouples byte acceptance from result back-pressure.
    nlr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (cls_out)
    );

    // The scanner advances only when its output register can take a result.
    nlr_back #(
        .LEN_LIMIT (LEN_LIMIT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_data        (cls_out),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

[sv/nlr_checker.sv]
module nlr_checker import nlr_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // A stalled result holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("result changed while stalled");

    // A token that is still open always consumed its byte and shows no type.
    a_open_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |->
            (o_m_axis_tdata[0] && (o_m_axis_tdata[3:1] == TT_BIN)))
        else $error("open token without consumed byte or with a type");

    // Only the imaginary suffix both consumes its byte and ends the token.
    a_imag_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast && o_m_axis_tdata[0]) |->
            (o_m_axis_tdata[3:1] == TT_IMAG))
        else $error("consumed end byte is not an imaginary suffix");

    // An error token has consumed nothing.
    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast && (o_m_axis_tdata[3:1] == TT_ERR)) |->
            (!o_m_axis_tdata[0] && (o_m_axis_tdata[11:4] == 8'd0)))
        else $error("error token with nonzero length");

endmodule

bind numeric_literal_recognizer_top nlr_checker u_nlr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
